### rtl/first_fit_core_allocator_assert.svh
// Assertion macros used by the top level of the core allocator.
`ifndef FIRST_FIT_CORE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CORE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FFCA_CHK_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FFCA_CHK_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffca_pkg.sv
// Types, codes and constants of the first-fit core allocator.
`default_nettype none

package ffca_pkg;

  // Default size of the owner table
  localparam int DEF_CORES   = 64;
  // Most cores one allocate request may be granted
  localparam int MAX_RESULTS = 64;

  // Field widths
  localparam int JOB_W    = 8;
  localparam int CNT_W    = 7;
  localparam int CORE_W   = 6;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 7;
  localparam int CIDX_W   = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  // Register reset values
  localparam logic [CFG_W-1:0] SERVERS_RST = 7'd16;
  localparam logic [CFG_W-1:0] CPS_RST     = 7'd4;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_SERVERS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CPS     = 2'd1;

  // Request kinds
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_GRANT    = 2'd0,
    STAT_FAIL     = 2'd1,
    STAT_RELEASED = 2'd2
  } status_t;

  // One owner table entry
  typedef struct packed {
    logic             busy;
    logic [JOB_W-1:0] owner;
  } entry_t;

endpackage

`default_nettype wire

### rtl/ffca_table.sv
// Owner table: one write port, one read port, registered read data.
`default_nettype none

module ffca_table #(
  parameter int CORES = ffca_pkg::DEF_CORES
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(CORES)-1:0] waddr,
  input  ffca_pkg::entry_t         wdata,
  input  wire  [$clog2(CORES)-1:0] raddr,
  output ffca_pkg::entry_t         rdata
);

  ffca_pkg::entry_t mem [CORES];

  // Write and read the entry array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ffca_ctrl.sv
// Sequencer: clears, recounts, allocates and releases over the owner table.
`default_nettype none

module ffca_ctrl #(
  parameter int CORES = ffca_pkg::DEF_CORES
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr,
  input  wire  [$clog2(CORES):0]            act_n,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [ffca_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire                               s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [ffca_pkg::M_DATA_W-1:0]     m_tdata,
  output logic [ffca_pkg::STAT_W-1:0]       m_tuser,
  output logic                              m_tlast,
  output logic                              mem_we,
  output logic [$clog2(CORES)-1:0]          mem_waddr,
  output ffca_pkg::entry_t                  mem_wdata,
  output logic [$clog2(CORES)-1:0]          mem_raddr,
  input  ffca_pkg::entry_t                  mem_rdata
);

  localparam int AW     = $clog2(CORES);
  localparam int NW     = AW + 1;
  localparam int CNTW   = ffca_pkg::CNT_W;
  localparam int COREW  = ffca_pkg::CORE_W;
  localparam int JOBW   = ffca_pkg::JOB_W;
  localparam int CMPW   = (NW > CNTW) ? NW : CNTW;
  localparam int PADW   = ffca_pkg::M_DATA_W - COREW - 2 * CNTW;
  localparam logic [AW-1:0]   LAST_P  = AW'(CORES - 1);
  localparam logic [CNTW-1:0] MAX_REQ = CNTW'(ffca_pkg::MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RECOUNT,
    ST_ALLOC,
    ST_RELEASE,
    ST_REPLY
  } state_t;

  state_t                state;
  logic [AW-1:0]         p;
  logic [JOBW-1:0]       job;
  logic [CNTW-1:0]       remain;
  logic [NW-1:0]         free_count;
  logic [NW-1:0]         free_after;
  logic [NW-1:0]         freed;
  logic                  pend;
  ffca_pkg::status_t     reply_status;
  ffca_pkg::status_t     out_status;
  logic [COREW-1:0]      out_core;
  logic [CNTW-1:0]       out_freed;
  logic [CNTW-1:0]       out_free;

  logic [JOBW-1:0]       in_job;
  logic [CNTW-1:0]       want;
  logic                  too_big;
  logic                  in_range;
  logic                  last_p;
  logic                  is_free;
  logic                  hit;
  logic                  out_space;
  logic                  grant;
  logic                  advance;
  logic                  scanning;
  logic                  load;

  // Decode the request word
  assign in_job = s_tdata[JOBW-1:0];
  assign want   = s_tdata[JOBW +: CNTW];
  assign too_big = (want == '0) || (CMPW'(want) > CMPW'(free_count)) || (want > MAX_REQ);

  // Judge the entry whose read data is at hand
  assign in_range  = ({1'b0, p} < act_n);
  assign last_p    = (p == LAST_P);
  assign is_free   = !mem_rdata.busy && in_range;
  assign hit       = mem_rdata.busy && (mem_rdata.owner == job);
  assign out_space = !m_tvalid || m_tready;
  assign grant     = (state == ST_ALLOC) && is_free && out_space;
  assign advance   = (state == ST_ALLOC) ? (!is_free || out_space) : 1'b1;
  assign scanning  = (state == ST_ALLOC) || (state == ST_RELEASE) || (state == ST_RECOUNT);
  assign load      = grant || ((state == ST_REPLY) && out_space);

  // Read the next entry, or re-read this one while the output stalls
  always_comb begin
    if (scanning) begin
      mem_raddr = advance ? (p + AW'(1)) : p;
    end else begin
      mem_raddr = '0;
    end
  end

  // Write back granted, released and cleared entries
  always_comb begin
    mem_waddr = p;
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_ALLOC: begin
        mem_we          = grant;
        mem_wdata.busy  = 1'b1;
        mem_wdata.owner = job;
      end
      ST_RELEASE: begin
        mem_we          = hit;
        mem_wdata.owner = mem_rdata.owner;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE) && !pend;
  assign m_tuser  = out_status;
  assign m_tdata  = {{PADW{1'b0}}, out_free, out_freed, out_core};

  // Sequence the passes and hold the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      p        <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a new result word or drop the one taken
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          p <= p + AW'(1);
          if (last_p) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          p <= '0;
          if (pend) begin
            state      <= ST_RECOUNT;
            free_count <= '0;
          end else if (s_tvalid) begin
            job   <= in_job;
            freed <= '0;
            if (s_tuser == ffca_pkg::ACT_RELEASE) begin
              state <= ST_RELEASE;
            end else if (too_big) begin
              reply_status <= ffca_pkg::STAT_FAIL;
              state        <= ST_REPLY;
            end else begin
              remain     <= want;
              free_after <= free_count - NW'(want);
              state      <= ST_ALLOC;
            end
          end
        end
        ST_RECOUNT: begin
          if (cfg_wr) begin
            state <= ST_IDLE;
          end else begin
            if (is_free) begin
              free_count <= free_count + NW'(1);
            end
            p <= p + AW'(1);
            if (last_p) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_ALLOC: begin
          if (advance) begin
            p <= p + AW'(1);
          end
          if (grant) begin
            out_status <= ffca_pkg::STAT_GRANT;
            out_core   <= COREW'(p);
            out_freed  <= '0;
            out_free   <= CNTW'(free_after);
            m_tlast    <= (remain == CNTW'(1));
            remain     <= remain - CNTW'(1);
            if (remain == CNTW'(1)) begin
              state      <= ST_IDLE;
              free_count <= free_after;
            end
          end
        end
        ST_RELEASE: begin
          p <= p + AW'(1);
          if (hit) begin
            freed <= freed + NW'(1);
            if (in_range) begin
              free_count <= free_count + NW'(1);
            end
          end
          if (last_p) begin
            reply_status <= ffca_pkg::STAT_RELEASED;
            state        <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          if (out_space) begin
            out_status <= reply_status;
            out_core   <= '0;
            out_freed  <= CNTW'(freed);
            out_free   <= CNTW'(free_count);
            m_tlast    <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Ask for a fresh count after the clearing pass and after a register write
      if (cfg_wr || ((state == ST_CLEAR) && last_p)) begin
        pend <= 1'b1;
      end else if ((state == ST_IDLE) && pend) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/first_fit_core_allocator.sv
// Top level of the first-fit core allocator: registers, sequencer and owner table.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  request word: kind, job, core count
//  m_*      out        m_tvalid / m_tready  result word: core, counts, status, last
//  cfg_*    in         cfg_valid/cfg_ready  register index and value
//
// An allocate of N cores is accepted, then scans one entry per cycle up to the N-th
// free core (at most CORES entries), holding an entry while the output stalls; a refused
// allocate is accepted and then replies. A release is accepted, scans every entry and
// replies once the output has room. After reset a clearing pass, an idle state and a
// recount over the table run before the first request; a register write starts a recount.
// The result register lets a request be taken while the last result waits.
`default_nettype none

module first_fit_core_allocator #(
  parameter int CORES = ffca_pkg::DEF_CORES
) (
  input  wire                            clk,
  input  wire                            rst,
  // request: tdata = job_id[7:0], task_count[14:8]; tuser = action
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [ffca_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire                            s_tuser,
  // result: tdata = core_index[5:0], freed_count[12:6], free_after[19:13]; tuser = status
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [ffca_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [ffca_pkg::STAT_W-1:0]    m_tuser,
  output logic                           m_tlast,
  // register writes
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [ffca_pkg::CIDX_W-1:0]    cfg_index,
  input  wire  [ffca_pkg::CFG_W-1:0]     cfg_data
);

`include "first_fit_core_allocator_assert.svh"

  localparam int AW   = $clog2(CORES);
  localparam int NW   = AW + 1;
  localparam int PW   = 2 * ffca_pkg::CFG_W;

  logic [ffca_pkg::CFG_W-1:0] server_count;
  logic [ffca_pkg::CFG_W-1:0] cores_per_server;
  logic [PW-1:0]              prod;
  logic [NW-1:0]              act_n;
  logic                       cfg_wr;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  ffca_pkg::entry_t           mem_wdata;
  ffca_pkg::entry_t           mem_rdata;

  // Take register writes at once
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid &&
                     ((cfg_index == ffca_pkg::REG_SERVERS) || (cfg_index == ffca_pkg::REG_CPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count     <= ffca_pkg::SERVERS_RST;
      cores_per_server <= ffca_pkg::CPS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ffca_pkg::REG_SERVERS) begin
        server_count <= cfg_data;
      end
      if (cfg_index == ffca_pkg::REG_CPS) begin
        cores_per_server <= cfg_data;
      end
    end
  end

  // Size of the active range, capped at the table size
  assign prod = PW'(server_count) * PW'(cores_per_server);

  always_ff @(posedge clk) begin
    act_n <= (prod > PW'(CORES)) ? NW'(CORES) : NW'(prod);
  end

  ffca_ctrl #(
    .CORES (CORES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .act_n     (act_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ffca_table #(
    .CORES (CORES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Checks on the sequencer
  `FFCA_CHK_IMP(a_idle_no_write, clk, rst, s_tready, !mem_we, "owner table written while idle")
  `FFCA_CHK_NXT(a_one_request, clk, rst, s_tvalid && s_tready, !s_tready, "second request taken")
  `FFCA_CHK_IMP(a_single_last, clk, rst, m_tvalid && (m_tuser != ffca_pkg::STAT_GRANT), m_tlast, "single result without last")

endmodule

`default_nettype wire
